FILE: hdl/bgff_pkg.sv
// Package: shared constants and types for the block grid flood fill.
package bgff_pkg;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int NUM_CLASSES = 32;
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = 12;
    localparam int CNT_W       = 13;
    localparam int DIM_W       = 7;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 6;
    localparam int NBR         = 8;
    localparam int ROW_CAP     = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int COL_CAP     = (MAX_COLS < 64) ? MAX_COLS : 64;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;

    typedef logic signed [1:0] t_step;
    localparam t_step ROW_STEP [NBR] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                         2'sd0, -2'sd1, -2'sd1, -2'sd1};
    localparam t_step COL_STEP [NBR] = '{-2'sd1, -2'sd1, 2'sd0, 2'sd1,
                                         2'sd1, 2'sd1, 2'sd0, -2'sd1};
endpackage

FILE: hdl/bgff_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module bgff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: hdl/block_grid_flood_fill.sv
// Top level: presence table, search sequencer, stack and row output.
// A load beat writes the presence table as it is accepted. A search first
// clears the 64-row visited map with a sweep. It then scans the presence
// table in raster order until the first hit. Each region block is then
// popped (POP, POPW) and its eight neighbours are tested through the single
// presence read port. A neighbour off the grid is skipped in the address
// step. One on the grid goes through address, read wait and test, and a
// push step when it is pushed. The stack holds each block as packed row and
// column. Rows are then read from the visited map and sent, each through
// EMIT, EMITW and OUT; OUT waits while the receiver stalls. The input stays
// blocked until the last row is registered. After reset no clearing pass is
// needed: the per-search sweep clears the visited map.
module block_grid_flood_fill (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [11:0] i_block_index,
    input  logic [31:0] i_class_bits,
    input  logic [4:0]  i_class_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_row_index,
    output logic [63:0] o_row_mask,
    output logic        o_found,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bgff_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_SCANW = 4'd3;
    localparam logic [3:0] ST_POP   = 4'd4;
    localparam logic [3:0] ST_POPW  = 4'd5;
    localparam logic [3:0] ST_NBR   = 4'd6;
    localparam logic [3:0] ST_NBRW  = 4'd7;
    localparam logic [3:0] ST_VIS   = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;
    localparam logic [3:0] ST_EMITW = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;
    localparam logic [3:0] ST_PUSH  = 4'd12;

    logic [DIM_W-1:0] r_grid_rows, r_grid_cols;
    logic [3:0]       r_state;
    logic [4:0]       r_cls;
    logic             r_cls_ok;
    logic [IDX_W-1:0] r_scan;
    logic [ROW_W-1:0] r_br, r_nr_q;
    logic [COL_W-1:0] r_bc, r_nc_q;
    logic [2:0]       r_k;
    logic [CNT_W-1:0] r_sp;
    logic             r_found;
    logic [ROW_W:0]   r_row;
    logic [63:0]      r_mask_q;
    logic [ROW_W-1:0] r_oi;
    logic [63:0]      r_om;
    logic             r_of, r_ol, r_ov;

    // effective grid size
    logic [DIM_W-1:0] w_rows, w_cols;
    assign w_rows = (r_grid_rows == '0) ? DIM_W'(1) :
                    (r_grid_rows > DIM_W'(ROW_CAP)) ? DIM_W'(ROW_CAP) : r_grid_rows;
    assign w_cols = (r_grid_cols == '0) ? DIM_W'(1) :
                    (r_grid_cols > DIM_W'(COL_CAP)) ? DIM_W'(COL_CAP) : r_grid_cols;

    // APB port
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            REG_ROWS[0]: prdata = {25'd0, r_grid_rows};
            default:     prdata = {25'd0, r_grid_cols};
        endcase
        if (paddr[1:0] != 2'd0) prdata = '0;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= DIM_W'(64);
            r_grid_cols <= DIM_W'(64);
        end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
            if (paddr[2] == REG_ROWS[0]) r_grid_rows <= pwdata[DIM_W-1:0];
            else if (paddr[2] == REG_COLS[0]) r_grid_cols <= pwdata[DIM_W-1:0];
        end
    end

    // scan coordinates: row/col tracked by counters
    logic [ROW_W:0] r_sr;
    logic [COL_W:0] r_sc;

    // neighbour coordinates
    logic signed [ROW_W+1:0] w_nr;
    logic signed [COL_W+1:0] w_nc;
    logic                    w_nok;
    assign w_nr  = $signed({2'b00, r_br}) + ROW_STEP[r_k];
    assign w_nc  = $signed({2'b00, r_bc}) + COL_STEP[r_k];
    assign w_nok = !w_nr[ROW_W+1] && !w_nc[COL_W+1] &&
                   (w_nr[ROW_W:0] < w_rows) && (w_nc[COL_W:0] < w_cols);

    // raster index of (row, col): row*cols+col, 12 bits
    function automatic logic [IDX_W-1:0] rast(input logic [ROW_W-1:0] r,
                                              input logic [COL_W-1:0] c,
                                              input logic [DIM_W-1:0] n);
        logic [ROW_W+DIM_W-1:0] p;
        p = r * n;
        return IDX_W'(p + c);
    endfunction

    // memories
    logic             w_p_we;
    logic [IDX_W-1:0] w_p_ra;
    logic [31:0]      w_p_rd;
    logic             w_v_we;
    logic [ROW_W-1:0] w_v_wa, w_v_ra;
    logic [63:0]      w_v_wd, w_v_rd;
    logic             w_s_we;
    logic [IDX_W-1:0] w_s_wa, w_s_ra, w_s_wd, w_s_rd;

    bgff_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_pres (
        .i_clk, .i_we(w_p_we), .i_waddr(i_block_index), .i_wdata(i_class_bits),
        .i_raddr(w_p_ra), .o_rdata(w_p_rd));
    bgff_ram #(.WIDTH(64), .DEPTH(64)) u_vis (
        .i_clk, .i_we(w_v_we), .i_waddr(w_v_wa), .i_wdata(w_v_wd),
        .i_raddr(w_v_ra), .o_rdata(w_v_rd));
    bgff_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_DEPTH)) u_stack (
        .i_clk, .i_we(w_s_we), .i_waddr(w_s_wa), .i_wdata(w_s_wd),
        .i_raddr(w_s_ra), .o_rdata(w_s_rd));

    logic w_hit;
    assign w_hit = w_p_rd[r_cls];

    assign o_ready = (r_state == ST_IDLE);
    logic w_acc;
    assign w_acc = i_valid && o_ready;

    // memory controls
    always_comb begin
        w_p_we = w_acc && !i_kind;
        w_p_ra = (r_state == ST_NBR)  ? rast(w_nr[ROW_W-1:0], w_nc[COL_W-1:0], w_cols) :
                 (r_state == ST_NBRW) ? rast(r_nr_q, r_nc_q, w_cols)
                                      : rast(r_sr[ROW_W-1:0], r_sc[COL_W-1:0], w_cols);
        w_v_we = 1'b0;
        w_v_wa = r_row[ROW_W-1:0];
        w_v_wd = '0;
        w_v_ra = (r_state == ST_NBRW || r_state == ST_NBR) ? w_nr[ROW_W-1:0]
                                                           : r_row[ROW_W-1:0];
        if (r_state == ST_NBRW || r_state == ST_VIS) w_v_ra = r_nr_q;
        if (r_state == ST_CLR) begin
            w_v_we = 1'b1;
        end else if (r_state == ST_SCANW && w_hit) begin
            w_v_we = 1'b1;
            w_v_wa = r_sr[ROW_W-1:0];
            w_v_wd = 64'd1 << r_sc[COL_W-1:0];
        end else if (r_state == ST_PUSH) begin
            w_v_we = 1'b1;
            w_v_wa = r_nr_q;
            w_v_wd = w_v_rd | (64'd1 << r_nc_q);
        end
        w_s_we = (r_state == ST_PUSH) || (r_state == ST_SCANW && w_hit);
        w_s_wa = r_sp[IDX_W-1:0];
        w_s_wd = (r_state == ST_PUSH) ? {r_nr_q, r_nc_q}
                                      : {r_sr[ROW_W-1:0], r_sc[COL_W-1:0]};
        w_s_ra = IDX_W'(r_sp - CNT_W'(1));
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_sp    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && i_kind) begin
                        r_cls    <= i_class_index;
                        r_cls_ok <= 32'(i_class_index) < NUM_CLASSES;
                        r_row    <= '0;
                        r_found  <= 1'b0;
                        r_sp     <= '0;
                        r_state  <= ST_CLR;
                    end
                end
                ST_CLR: begin
                    r_row <= r_row + 1'b1;
                    if (r_row == 7'd63) begin
                        r_sr <= '0;
                        r_sc <= '0;
                        r_state <= r_cls_ok ? ST_SCAN : ST_EMIT;
                        r_row <= '0;
                    end
                end
                ST_SCAN: r_state <= ST_SCANW;
                ST_SCANW: begin
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_sp    <= CNT_W'(1);
                        r_state <= ST_POP;
                    end else if (r_sc + 1'b1 < w_cols) begin
                        r_sc <= r_sc + 1'b1;
                        r_state <= ST_SCAN;
                    end else if (r_sr + 1'b1 < w_rows) begin
                        r_sc <= '0;
                        r_sr <= r_sr + 1'b1;
                        r_state <= ST_SCAN;
                    end else begin
                        r_row <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_POP: begin
                    if (r_sp == '0) begin
                        r_row <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_POPW;
                    end
                end
                ST_POPW: begin
                    r_sp <= r_sp - 1'b1;
                    r_br <= w_s_rd[IDX_W-1:COL_W];
                    r_bc <= w_s_rd[COL_W-1:0];
                    r_k  <= '0;
                    r_state <= ST_NBR;
                end
                ST_NBR: begin
                    r_nr_q <= w_nr[ROW_W-1:0];
                    r_nc_q <= w_nc[COL_W-1:0];
                    if (w_nok) begin
                        r_state <= ST_NBRW;
                    end else begin
                        r_k <= r_k + 1'b1;
                        if (r_k == 3'd7) r_state <= ST_POP;
                    end
                end
                ST_NBRW: r_state <= ST_VIS;
                ST_VIS: begin
                    r_k <= r_k + 1'b1;
                    if (w_p_rd[r_cls] && !w_v_rd[r_nc_q]) begin
                        r_state <= ST_PUSH;
                    end else begin
                        r_state <= (r_k == 3'd7) ? ST_POP : ST_NBR;
                    end
                end
                ST_PUSH: begin
                    r_sp <= r_sp + 1'b1;
                    r_state <= (r_k == 3'd0) ? ST_POP : ST_NBR;
                end
                ST_EMIT: r_state <= ST_EMITW;
                ST_EMITW: begin
                    r_mask_q <= w_v_rd;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_ov <= 1'b1;
                        r_oi <= r_row[ROW_W-1:0];
                        r_om <= r_mask_q;
                        r_of <= r_found;
                        r_ol <= (r_row + 1'b1 == w_rows);
                        r_row <= r_row + 1'b1;
                        r_state <= (r_row + 1'b1 == w_rows) ? ST_IDLE : ST_EMIT;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (r_ov && i_ready && !(r_state == ST_OUT)) r_ov <= 1'b0;
        end
    end

    assign o_valid     = r_ov;
    assign o_row_index = r_oi;
    assign o_row_mask  = r_om;
    assign o_found     = r_of;
    assign o_last      = r_ol;

    // checks
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CNT_W'(TABLE_DEPTH)) else $error("stack overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_row_mask))
        else $error("output beat changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
endmodule

FILE: tb/sv/block_grid_flood_fill_tb.sv
// Testbench for block_grid_flood_fill: region search checked against a local flood fill.
`timescale 1ns / 100ps

module block_grid_flood_fill_tb;
    import bgff_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [5:0]  row;
        logic [63:0] mask;
        logic        found;
        logic        last;
    } row_beat_t;

    // Track the presence table and grid size, predict mask rows per search
    class flood_scoreboard;
        bit [31:0] presence [TABLE_DEPTH];
        int        rows = 64;
        int        cols = 64;
        row_beat_t rows_due [$];
        int        mismatches = 0;

        function int clamp_dim(int v, int cap);
            if (v < 1) return 1;
            if (v > cap) return cap;
            return v;
        endfunction

        function void set_grid(int row_reg, int col_reg);
            rows = clamp_dim(row_reg, ROW_CAP);
            cols = clamp_dim(col_reg, COL_CAP);
        endfunction

        function void note_item(bit kind, bit [11:0] idx, bit [31:0] bits, bit [4:0] cls);
            bit [63:0] vis [64];
            int        pend [TABLE_DEPTH];
            int        sp;
            int        total, start, cur, br, bc, nr, nc, k, r;
            bit        hit;
            row_beat_t beat;
            if (kind == 1'b0) begin
                presence[idx] = bits;
                return;
            end
            total = rows * cols;
            hit = 1'b0;
            start = 0;
            sp = 0;
            for (r = 0; r < 64; r++) vis[r] = '0;
            if (cls < NUM_CLASSES) begin
                for (int j = 0; j < total; j++) begin
                    if (presence[j][cls]) begin
                        start = j;
                        hit = 1'b1;
                        break;
                    end
                end
            end
            // Mark on push, pop from the top
            if (hit) begin
                vis[start / cols][start % cols] = 1'b1;
                pend[sp] = start;
                sp++;
                while (sp > 0) begin
                    sp--;
                    cur = pend[sp];
                    br = cur / cols;
                    bc = cur % cols;
                    for (k = 0; k < NBR; k++) begin
                        nr = br + int'(ROW_STEP[k]);
                        nc = bc + int'(COL_STEP[k]);
                        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
                        if (vis[nr][nc]) continue;
                        if (presence[nr * cols + nc][cls]) begin
                            vis[nr][nc] = 1'b1;
                            pend[sp] = nr * cols + nc;
                            sp++;
                        end
                    end
                end
            end
            for (r = 0; r < rows; r++) begin
                beat.row = r[5:0];
                beat.mask = vis[r];
                beat.found = hit;
                beat.last = (r + 1 == rows);
                rows_due = {rows_due, beat};
            end
        endfunction

        function void check_row(row_beat_t got);
            row_beat_t want;
            if (rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row beat: row %0d mask %h", got.row, got.mask);
                return;
            end
            want = rows_due.pop_front();
            if (got.row !== want.row || got.mask !== want.mask ||
                got.found !== want.found || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"row mismatch: exp row %0d mask %h found %b last %b, ",
                              "got row %0d mask %h found %b last %b"},
                             want.row, want.mask, want.found, want.last,
                             got.row, got.mask, got.found, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_kind;
    logic [11:0] i_block_index;
    logic [31:0] i_class_bits;
    logic [4:0]  i_class_index;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_row_index;
    logic [63:0] o_row_mask;
    logic        o_found;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    flood_scoreboard sb = new();
    bit  calm = 1'b0;
    bit  long_hold = 1'b0;
    int  cycles = 0;

    block_grid_flood_fill u_top (.*);

    always #10 i_clk = ~i_clk;

    // Drive all inputs to known values
    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_kind <= 1'b0;
        i_block_index <= '0;
        i_class_bits <= '0;
        i_class_index <= '0;
        i_ready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
    end

    // Abort on timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("block_grid_flood_fill verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
                i_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Check each accepted row beat
    always @(posedge i_clk) begin
        row_beat_t got;
        if (i_rst_n && o_valid && i_ready) begin
            got.row = o_row_index;
            got.mask = o_row_mask;
            got.found = o_found;
            got.last = o_last;
            sb.check_row(got);
        end
    end

    // Offer one beat, with an optional idle burst first
    task automatic send_beat(bit kind, bit [11:0] idx, bit [31:0] bits, bit [4:0] cls);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_block_index <= idx;
        i_class_bits <= bits;
        i_class_index <= cls;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(kind, idx, bits, cls);
    endtask

    task automatic load_block(int idx, bit [31:0] bits);
        send_beat(1'b0, idx[11:0], bits, 5'($urandom));
    endtask

    task automatic search_class(int cls);
        send_beat(1'b1, 12'($urandom), $urandom, cls[4:0]);
    endtask

    // Let the block drain, then hold the inputs idle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.rows_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Setup phase, access phase, then return to idle
    task automatic write_reg(logic [1:0] reg_id, int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_id[0], 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(int row_reg, int col_reg);
        write_reg(REG_ROWS, row_reg);
        write_reg(REG_COLS, col_reg);
        sb.set_grid(row_reg & 7'h7f, col_reg & 7'h7f);
    endtask

    function automatic bit [31:0] rand_presence();
        case ($urandom_range(0, 3))
            0: return $urandom & $urandom;
            1: return $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Fill the grid, then mix loads and searches
    task automatic run_phase(int row_reg, int col_reg, int n_items, bit hold_off);
        int total;
        drain();
        set_grid(row_reg, col_reg);
        total = sb.rows * sb.cols;
        for (int j = 0; j < total; j++) load_block(j, rand_presence());
        if (hold_off) begin
            long_hold = 1'b1;
            search_class($urandom_range(0, 31));
        end
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 2) == 0)
                search_class($urandom_range(0, 31));
            else if ($urandom_range(0, 4) == 0)
                load_block($urandom_range(0, 4095), rand_presence());
            else
                load_block($urandom_range(0, total - 1), rand_presence());
        end
    endtask

    initial begin
        int total;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: 3x5 grid, corner cases of presence and class
        set_grid(3, 5);
        for (int j = 0; j < 15; j++) load_block(j, 32'hffff_ffff);
        search_class(0);
        search_class(31);
        load_block(4095, 32'hffff_ffff);
        load_block(0, 32'h0000_0000);
        load_block(7, 32'h0000_0000);
        search_class(5);
        for (int j = 0; j < 15; j++) load_block(j, 32'h7fff_ffff);
        search_class(31);
        drain();

        // Random phases: zero register values, then a long receiver hold-off
        run_phase(0, 0, 8, 1'b0);
        run_phase(4, 4, 10, 1'b1);

        // Row count saturates, single column, no idling
        drain();
        calm = 1'b1;
        set_grid(127, 1);
        total = sb.rows * sb.cols;
        for (int j = 0; j < total; j++) load_block(j, rand_presence());
        for (int n = 0; n < 2; n++) search_class($urandom_range(0, 31));
        drain();

        if (sb.mismatches == 0 && sb.rows_due.size() == 0) begin
            $display("block_grid_flood_fill verification clean");
        end else begin
            $display("block_grid_flood_fill verification failed");
        end
        $finish;
    end
endmodule

FILE: block_grid_flood_fill.f
hdl/bgff_pkg.sv
hdl/bgff_ram.sv
hdl/block_grid_flood_fill.sv
tb/sv/block_grid_flood_fill_tb.sv
